// ===== rtl/core/ggbi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the geoid grid bilinear interpolation unit.
package ggbi_pkg;

   localparam int GRID_COLS_DEF = 421;
   localparam int GRID_ROWS_DEF = 381;

   localparam logic [1:0] MODE_QUERY = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_HEIGHT     = 2'd0;
   localparam logic [1:0] STATUS_NOT_LOADED = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE    = 2'd2;
   localparam logic [1:0] STATUS_DONE       = 2'd3;

   localparam logic signed [32:0] LON_MIN_Q24 = -33'sd92274688;
   localparam logic signed [32:0] LON_MAX_Q24 = 33'sd142606336;
   localparam logic signed [31:0] LAT_MIN_Q24 = 32'sd704643072;
   localparam logic signed [31:0] LAT_MAX_Q24 = 32'sd864026624;

   localparam int COLS_PER_DEG = 30;
   localparam int ROWS_PER_DEG = 40;

   localparam logic [16:0] FRAC_ONE = 17'h10000;

   localparam int DIFF_W = 28;
   localparam int POS_W  = 33;
   localparam int WPROD_W = 33;
   localparam int PROD_W = 52;
   localparam int ACC_W  = 52;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOCATE,
      S_READ,
      S_DRAIN,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic        in_bounds;
      logic [16:0] fx;
      logic [16:0] fy;
   } loc_type;

endpackage

// ===== rtl/core/ggbi_grid_ram.sv =====
`timescale 1ns / 1ps
// Single-port grid memory with registered read data.
module ggbi_grid_ram #(
   parameter int DEPTH = ggbi_pkg::GRID_COLS_DEF * ggbi_pkg::GRID_ROWS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                we,
   input  logic                re,
   input  logic [AW-1:0]       addr,
   input  logic signed [17:0]  wdata,
   output logic signed [17:0]  rdata
);

   logic signed [17:0] mem [DEPTH];
   logic signed [17:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ggbi_locate.sv =====
`timescale 1ns / 1ps
// Area check, grid position, edge clamp and base address of a query.
module ggbi_locate #(
   parameter int GRID_COLS = ggbi_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = ggbi_pkg::GRID_ROWS_DEF,
   parameter int AW        = $clog2(GRID_COLS * GRID_ROWS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [32:0]   longitude,
   input  logic signed [31:0]   latitude,
   output logic                 done,
   output ggbi_pkg::loc_type    loc,
   output logic [AW-1:0]        base_addr
);

   localparam int CW = $clog2(GRID_COLS);
   localparam int RW = $clog2(GRID_ROWS);

   logic                          v0_ff, v1_ff, v2_ff, done_ff;
   logic signed [32:0]            lon_ff;
   logic signed [31:0]            lat_ff;
   logic                          in1_ff, in2_ff, in3_ff;
   logic [ggbi_pkg::DIFF_W-1:0]   dlon_ff, dlat_ff;
   logic [CW-1:0]                 col_ff;
   logic [RW-1:0]                 row_ff;
   logic [16:0]                   fx2_ff, fy2_ff, fx3_ff, fy3_ff;
   logic [AW-1:0]                 addr_ff;

   logic signed [33:0]            dlon_full;
   logic signed [32:0]            dlat_full;
   logic                          inside_in;
   logic [ggbi_pkg::POS_W-1:0]    cpos, rpos;
   logic [8:0]                    cbase, rbase;
   logic [CW-1:0]                 col_in;
   logic [RW-1:0]                 row_in;
   logic [16:0]                   fx_in, fy_in;

   always_comb begin
      dlon_full = 34'(lon_ff) - 34'(ggbi_pkg::LON_MIN_Q24);
      dlat_full = 33'(ggbi_pkg::LAT_MAX_Q24) - 33'(lat_ff);
      inside_in = (lon_ff >= ggbi_pkg::LON_MIN_Q24) && (lon_ff <= ggbi_pkg::LON_MAX_Q24) &&
                  (lat_ff >= ggbi_pkg::LAT_MIN_Q24) && (lat_ff <= ggbi_pkg::LAT_MAX_Q24);
   end

   always_comb begin
      cpos  = ggbi_pkg::POS_W'(dlon_ff) * ggbi_pkg::POS_W'(ggbi_pkg::COLS_PER_DEG);
      rpos  = ggbi_pkg::POS_W'(dlat_ff) * ggbi_pkg::POS_W'(ggbi_pkg::ROWS_PER_DEG);
      cbase = cpos[32:24];
      rbase = rpos[32:24];
      if (32'(cbase) > 32'(GRID_COLS - 2)) begin
         col_in = CW'(GRID_COLS - 2);
         fx_in  = ggbi_pkg::FRAC_ONE;
      end else begin
         col_in = CW'(cbase);
         fx_in  = {1'b0, cpos[23:8]};
      end
      if (32'(rbase) > 32'(GRID_ROWS - 2)) begin
         row_in = RW'(GRID_ROWS - 2);
         fy_in  = ggbi_pkg::FRAC_ONE;
      end else begin
         row_in = RW'(rbase);
         fy_in  = {1'b0, rpos[23:8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v0_ff   <= start;
         v1_ff   <= v0_ff;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         lon_ff <= longitude;
         lat_ff <= latitude;
      end
      if (v0_ff) begin
         in1_ff  <= inside_in;
         dlon_ff <= dlon_full[ggbi_pkg::DIFF_W-1:0];
         dlat_ff <= dlat_full[ggbi_pkg::DIFF_W-1:0];
      end
      if (v1_ff) begin
         in2_ff <= in1_ff;
         col_ff <= col_in;
         row_ff <= row_in;
         fx2_ff <= fx_in;
         fy2_ff <= fy_in;
      end
      if (v2_ff) begin
         in3_ff  <= in2_ff;
         fx3_ff  <= fx2_ff;
         fy3_ff  <= fy2_ff;
         addr_ff <= AW'(32'(row_ff) * 32'(GRID_COLS) + 32'(col_ff));
      end
   end

   assign done          = done_ff;
   assign loc.in_bounds = in3_ff;
   assign loc.fx        = fx3_ff;
   assign loc.fy        = fy3_ff;
   assign base_addr     = addr_ff;

endmodule

// ===== rtl/core/ggbi_blend.sv =====
`timescale 1ns / 1ps
// Weighted accumulation of the four neighbor entries and final rounding.
module ggbi_blend (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 issue,
   input  logic [1:0]           corner,
   input  logic [16:0]          fx,
   input  logic [16:0]          fy,
   input  logic signed [17:0]   rdata,
   output logic                 done,
   output logic signed [17:0]   height
);

   logic                               v1_ff, v2_ff, last_ff, done_ff;
   logic [1:0]                         k1_ff, k2_ff;
   logic [ggbi_pkg::WPROD_W-1:0]       wprod_ff;
   logic signed [ggbi_pkg::PROD_W-1:0] prod_ff;
   logic signed [ggbi_pkg::ACC_W-1:0]  acc_ff;
   logic signed [17:0]                 height_ff;

   logic [16:0]                        wx, wy;
   logic signed [ggbi_pkg::ACC_W-1:0]  rsum;

   always_comb begin
      wx   = corner[0] ? fx : ggbi_pkg::FRAC_ONE - fx;
      wy   = corner[1] ? fy : ggbi_pkg::FRAC_ONE - fy;
      rsum = acc_ff + (ggbi_pkg::ACC_W'(1) <<< 31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= issue;
         v2_ff   <= v1_ff;
         last_ff <= v2_ff && (k2_ff == 2'd3);
         done_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         wprod_ff <= ggbi_pkg::WPROD_W'(34'(wx) * 34'(wy));
         k1_ff    <= corner;
      end
      if (v1_ff) begin
         prod_ff <= ggbi_pkg::PROD_W'($signed({1'b0, wprod_ff}) * rdata);
         k2_ff   <= k1_ff;
      end
      if (start) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (last_ff) begin
         height_ff <= rsum[49:32];
      end
   end

   assign done   = done_ff;
   assign height = height_ff;

endmodule

// ===== rtl/core/geoid_grid_bilinear_interp_unit.sv =====
`timescale 1ns / 1ps
// Top level of the geoid grid bilinear interpolation unit.
//
// Channels: req_* carries one item (query, load entry or clear) with valid/ready;
// rsp_* returns exactly one result item per request with valid/ready.
// An in-range load writes one grid entry; the last index marks the grid loaded.
// A clear drops the loaded mark only. A query returns the bilinear blend of four
// neighbor entries, or a status for grid not loaded or point outside the area.
// Load, clear and queries on an unloaded grid go straight to the result state,
// queries outside the area after the area check; a full query passes the area
// check, position and base address, reads the four corners from the single-port
// grid memory (one corner per cycle), drains the multiply-accumulate pipeline
// and rounds, then passes the output stage.
// One item is in work at a time; the next can be taken once the result has
// entered the output register, even while that result still waits.
// Reset clears the loaded mark and all control state; grid entries are kept
// and are undefined until written. A stalled receiver holds the result in the
// output register and holds the next item in its final state.
module geoid_grid_bilinear_interp_unit #(
   parameter int GRID_COLS = ggbi_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = ggbi_pkg::GRID_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic signed [32:0]  req_longitude,
   input  logic signed [31:0]  req_latitude,
   input  logic [17:0]         req_grid_index,
   input  logic signed [17:0]  req_grid_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [17:0]  rsp_height_correction,
   output logic [1:0]          rsp_status
);

   localparam int GRID_SIZE = GRID_COLS * GRID_ROWS;
   localparam int AW        = $clog2(GRID_SIZE);

   ggbi_pkg::state_type state_ff, state_in;
   logic [1:0]          rd_k_ff;
   logic                loaded_ff;
   logic [1:0]          res_status_ff;
   logic                rsp_valid_ff;
   logic signed [17:0]  rsp_height_ff;
   logic [1:0]          rsp_status_ff;

   logic                req_fire;
   logic                load_ok;
   logic                mem_we, mem_re, loc_start, rsp_load;
   logic [AW-1:0]       mem_addr, rd_addr, base_addr;
   logic signed [17:0]  mem_rdata;
   logic                loc_done, blend_done;
   ggbi_pkg::loc_type   loc;
   logic signed [17:0]  blend_height;

   assign req_fire = req_valid && req_ready;
   assign load_ok  = 32'(req_grid_index) < 32'(GRID_SIZE);
   assign rd_addr  = base_addr + ({AW{rd_k_ff[1]}} & AW'(GRID_COLS)) + AW'(rd_k_ff[0]);
   assign mem_addr = mem_we ? AW'(req_grid_index) : rd_addr;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ggbi_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_mode == ggbi_pkg::MODE_QUERY && loaded_ff) begin
                  state_in = ggbi_pkg::S_LOCATE;
               end else begin
                  state_in = ggbi_pkg::S_RESULT;
               end
            end
         end
         ggbi_pkg::S_LOCATE: begin
            if (loc_done) begin
               state_in = loc.in_bounds ? ggbi_pkg::S_READ : ggbi_pkg::S_RESULT;
            end
         end
         ggbi_pkg::S_READ: begin
            if (rd_k_ff == 2'd3) begin
               state_in = ggbi_pkg::S_DRAIN;
            end
         end
         ggbi_pkg::S_DRAIN: begin
            if (blend_done) begin
               state_in = ggbi_pkg::S_RESULT;
            end
         end
         ggbi_pkg::S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ggbi_pkg::S_IDLE;
            end
         end
         default: state_in = ggbi_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      loc_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ggbi_pkg::S_IDLE: begin
            req_ready = 1'b1;
            mem_we    = req_valid && req_mode == ggbi_pkg::MODE_LOAD && load_ok;
            loc_start = req_valid && req_mode == ggbi_pkg::MODE_QUERY && loaded_ff;
         end
         ggbi_pkg::S_READ: begin
            mem_re = 1'b1;
         end
         ggbi_pkg::S_RESULT: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ggbi_pkg::S_IDLE;
         rd_k_ff      <= 2'd0;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ggbi_pkg::S_READ) begin
            rd_k_ff <= rd_k_ff + 2'd1;
         end else begin
            rd_k_ff <= 2'd0;
         end
         if (req_fire && req_mode == ggbi_pkg::MODE_CLEAR) begin
            loaded_ff <= 1'b0;
         end else if (mem_we && 32'(req_grid_index) == 32'(GRID_SIZE - 1)) begin
            loaded_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (req_mode != ggbi_pkg::MODE_QUERY) begin
            res_status_ff <= ggbi_pkg::STATUS_DONE;
         end else if (!loaded_ff) begin
            res_status_ff <= ggbi_pkg::STATUS_NOT_LOADED;
         end else begin
            res_status_ff <= ggbi_pkg::STATUS_HEIGHT;
         end
      end else if (state_ff == ggbi_pkg::S_LOCATE && loc_done && !loc.in_bounds) begin
         res_status_ff <= ggbi_pkg::STATUS_OUTSIDE;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_height_ff <= (res_status_ff == ggbi_pkg::STATUS_HEIGHT) ? blend_height : 18'sd0;
      end
   end

   ggbi_grid_ram #(
      .DEPTH (GRID_SIZE),
      .AW    (AW)
   ) u_grid_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (req_grid_value),
      .rdata (mem_rdata)
   );

   ggbi_locate #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS),
      .AW        (AW)
   ) u_locate (
      .clock     (clock),
      .reset     (reset),
      .start     (loc_start),
      .longitude (req_longitude),
      .latitude  (req_latitude),
      .done      (loc_done),
      .loc       (loc),
      .base_addr (base_addr)
   );

   ggbi_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .start  (loc_start),
      .issue  (mem_re),
      .corner (rd_k_ff),
      .fx     (loc.fx),
      .fy     (loc.fy),
      .rdata  (mem_rdata),
      .done   (blend_done),
      .height (blend_height)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_height_correction = rsp_height_ff;
   assign rsp_status            = rsp_status_ff;

   a_blend_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      blend_done |-> state_ff == ggbi_pkg::S_DRAIN)
      else $error("blend finished outside drain");

   a_locate_done_in_locate: assert property (@(posedge clock) disable iff (reset)
      loc_done |-> state_ff == ggbi_pkg::S_LOCATE)
      else $error("locate finished outside locate");

   a_read_in_grid: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> 32'(rd_addr) < 32'(GRID_SIZE))
      else $error("grid read beyond last entry");

   a_loaded_after_load: assert property (@(posedge clock) disable iff (reset)
      $rose(loaded_ff) |-> $past(req_fire && req_mode == ggbi_pkg::MODE_LOAD))
      else $error("grid marked loaded without a load");

endmodule
